FILE: src/slu_pkg.sv
// ----------------------------------------------------------------------------
// Slope limiter package
// Shared widths, register and mode codes, payload types and the limb
// multiply helpers used by the limiter datapath and its divider.
// ----------------------------------------------------------------------------
package slu_pkg;

  // Field widths of the channels and the configuration port.
  localparam int IN_W        = 24;
  localparam int LIMIT_W     = 21;
  localparam int EPS_W       = 63;
  localparam int MODE_W      = 3;
  localparam int CFG_INDEX_W = 2;

  // Working width of numerator and denominator; all terms stay below 2^123.
  localparam int ABS_W  = 128;
  // Wide products are formed from 24-bit limbs times a 24-bit magnitude.
  localparam int LIMB_W = 24;
  localparam int LIMB_N = 5;
  localparam int MW     = LIMB_N * LIMB_W;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LIMITER_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EPSILON      = 2'd1;

  // Limiter formulas.
  localparam logic [MODE_W-1:0] MODE_VAN_ALBADA = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VENKAT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NISH_R3    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NISH_R4    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NISH_R5    = 3'd4;

  typedef struct packed {
    logic signed [IN_W-1:0] gradient;
    logic signed [IN_W-1:0] delta;
  } item_t;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] limit_value;
    logic                      saturated;
  } result_t;

  // Partial products of one wide-by-narrow multiply.
  typedef logic [LIMB_N-1:0][2*LIMB_W-1:0] pp_t;

  // Division request between the formula pipeline and the divider.
  typedef struct packed {
    logic [ABS_W-1:0] num;
    logic [ABS_W-1:0] den;
  } div_req_t;

  // One 24x24 product per limb of the wide operand.
  function automatic pp_t limb_mul(input logic [MW-1:0] a, input logic [LIMB_W-1:0] b);
    pp_t r;
    for (int i = 0; i < LIMB_N; i++) begin
      r[i] = a[i*LIMB_W +: LIMB_W] * b;
    end
    return r;
  endfunction

  // Sum of the shifted partial products.
  function automatic logic [ABS_W-1:0] limb_sum(input pp_t pp);
    logic [ABS_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < LIMB_N; i++) begin
      acc = acc + (ABS_W'(pp[i]) << (i * LIMB_W));
    end
    return acc;
  endfunction

endpackage

FILE: src/slu_div.sv
// ----------------------------------------------------------------------------
// Slope limiter divider
// Pipelined restoring divider: one quotient bit per stage, then sign,
// saturation to signed Q4.16 and the zero-denominator flag.
// ----------------------------------------------------------------------------
module slu_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  slu_pkg::div_req_t  req,
  output logic               result_valid,
  input  logic               result_stall,
  output slu_pkg::result_t   result
);
  import slu_pkg::*;

  // One extra quotient bit shows any factor beyond the signed range.
  localparam int QB = LIMIT_W + 1;
  localparam int RW = ABS_W + FRAC_BITS + QB;
  localparam int NS = QB + 2;
  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (LIMIT_W - 1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (LIMIT_W - 1));

  logic [NS-1:0]    vld;
  logic [NS-1:0]    en;
  logic [RW-1:0]    rem [QB+1];
  logic [ABS_W-1:0] dvs [QB+1];
  logic [QB-1:0]    quo [QB+1];
  logic             neg [QB+1];
  logic             dz  [QB+1];
  logic [ABS_W-1:0] num_abs;
  logic [ABS_W-1:0] den_abs;
  logic [QB-1:0]    lim;
  logic [QB-1:0]    mag;
  logic [QB-1:0]    sval;
  logic             sat;

  // A stage moves on when it is empty or the next one moves on.
  always_comb begin
    en[NS-1] = !vld[NS-1] || !result_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign req_stall    = !en[0];
  assign result_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Entry: magnitudes, result sign and the scaled dividend.
  assign num_abs = req.num[ABS_W-1] ? -req.num : req.num;
  assign den_abs = req.den[ABS_W-1] ? -req.den : req.den;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= RW'(num_abs) << FRAC_BITS;
      dvs[0] <= den_abs;
      quo[0] <= '0;
      neg[0] <= req.num[ABS_W-1] ^ req.den[ABS_W-1];
      dz[0]  <= (req.den == '0);
    end
  end

  // Quotient stages, most significant bit first.
  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int SH = QB - j;
    logic [RW:0] diff;

    assign diff = {1'b0, rem[j-1]} - {1'b0, RW'(dvs[j-1]) << SH};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= diff[RW] ? rem[j-1] : diff[RW-1:0];
        quo[j] <= quo[j-1] | (QB'(!diff[RW]) << SH);
        dvs[j] <= dvs[j-1];
        neg[j] <= neg[j-1];
        dz[j]  <= dz[j-1];
      end
    end
  end

  // Clip the magnitude to the range of its sign, then apply the sign.
  assign lim  = neg[QB] ? LIM_NEG : LIM_POS;
  assign sat  = quo[QB] > lim;
  assign mag  = sat ? lim : quo[QB];
  assign sval = neg[QB] ? -mag : mag;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result.limit_value <= dz[QB] ? '0 : LIMIT_W'(sval);
      result.saturated   <= dz[QB] | sat;
    end
  end

endmodule

FILE: src/slope_limiter_unit_core.sv
// ----------------------------------------------------------------------------
// Slope limiter unit
// Limiter factor from a projected gradient and a neighbour difference for
// Van Albada, Venkatakrishnan and Nishikawa R3, R4 and R5 limiters.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes a request (gradient, delta, signed Q7.16) when
//   item_valid is high and item_stall is low. The result channel offers
//   limit_value (signed Q4.16) and saturated under result_valid; the
//   receiver holds result_stall high to keep it.
//   The configuration channel writes limiter_mode (index 0) and epsilon
//   (index 1); cfg_ready is always high. Write only while no request is in
//   flight. Unused mode codes select Van Albada.
//   The pipeline has 11 formula stages built from registered 24x24
//   limb products, and a 24-stage divider made of an entry stage, 22
//   stages that each resolve one quotient bit, and the output register.
//   Throughput is one request per cycle without stalls. Each stage
//   advances when it is empty or its successor advances, so a stalled
//   result holds in the output register while earlier stages keep filling.
//   Reset clears all stage valid bits, sets Van Albada mode and epsilon
//   to one.
// ----------------------------------------------------------------------------
module slope_limiter_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  slu_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output slu_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [slu_pkg::EPS_W-1:0]           cfg_data
);
  import slu_pkg::*;

  localparam int NF   = 11;
  localparam int SQ_W = 2 * IN_W;
  localparam int Q_W  = SQ_W + 4;

  logic [MODE_W-1:0] limiter_mode;
  logic [EPS_W-1:0]  epsilon;
  logic              is_nish;

  // Configuration registers; the mode is stored already decoded.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_mode <= MODE_VAN_ALBADA;
      epsilon      <= EPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMITER_MODE: begin
          limiter_mode <= (cfg_data[MODE_W-1:0] > MODE_NISH_R5) ? MODE_VAN_ALBADA
                                                                : cfg_data[MODE_W-1:0];
        end
        REG_EPSILON: epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_nish = (limiter_mode == MODE_NISH_R3) || (limiter_mode == MODE_NISH_R4) ||
                   (limiter_mode == MODE_NISH_R5);

  // Elastic stage control for the formula pipeline.
  logic [NF-1:0] fv;
  logic [NF-1:0] fen;
  logic          div_stall;

  always_comb begin
    fen[NF-1] = !fv[NF-1] || !div_stall;
    for (int k = NF - 2; k >= 0; k--) begin
      fen[k] = !fv[k] || fen[k+1];
    end
  end

  assign item_stall = !fen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (fen[0]) begin
        fv[0] <= item_valid;
      end
      for (int k = 1; k < NF; k++) begin
        if (fen[k]) begin
          fv[k] <= fv[k-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic signed [IN_W-1:0] g0, d0;

  always_ff @(posedge clk) begin
    if (fen[0]) begin
      g0 <= item.gradient;
      d0 <= item.delta;
    end
  end

  // Stage 1: magnitudes, far-side test and the four base products.
  logic [IN_W-1:0]        p_abs, m_abs;
  logic [IN_W-1:0]        p1, m1;
  logic signed [SQ_W-1:0] dd1, gg1, dg1;
  logic [SQ_W-1:0]        pm1;
  logic                   far1, dneg1;

  assign p_abs = d0[IN_W-1] ? IN_W'(-d0) : IN_W'(d0);
  assign m_abs = g0[IN_W-1] ? IN_W'(-g0) : IN_W'(g0);

  always_ff @(posedge clk) begin
    if (fen[1]) begin
      p1    <= p_abs;
      m1    <= m_abs;
      dd1   <= d0 * d0;
      gg1   <= g0 * g0;
      dg1   <= d0 * g0;
      pm1   <= p_abs * m_abs;
      far1  <= is_nish && ({1'b0, p_abs} > {m_abs, 1'b0});
      dneg1 <= d0[IN_W-1];
    end
  end

  // Stage 2: quadratic terms, the first-order formulas and p^3 products.
  logic [Q_W-1:0]        q_c;
  logic signed [Q_W-1:0] n01_c, d01_c;
  logic [Q_W-1:0]        q2;
  logic signed [Q_W-1:0] n01_2, d01_2;
  logic [IN_W-1:0]       p2, m2;
  logic [SQ_W-1:0]       sq2, mm2;
  pp_t                   pp_cube2;
  logic                  far2, dneg2;

  always_comb begin
    // p^2 - 2pm + c*m^2, with c = 4 for R4 and 2 for R5.
    q_c = Q_W'(unsigned'(dd1)) - (Q_W'(pm1) << 1) +
          ((limiter_mode == MODE_NISH_R4) ? (Q_W'(unsigned'(gg1)) << 2)
                                          : (Q_W'(unsigned'(gg1)) << 1));
    n01_c = Q_W'(dd1) + (Q_W'(dg1) <<< 1);
    if (limiter_mode == MODE_VENKAT) begin
      d01_c = Q_W'(dd1) + Q_W'(dg1) + (Q_W'(gg1) <<< 1);
    end else begin
      d01_c = Q_W'(dd1) + (Q_W'(gg1) <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (fen[2]) begin
      q2       <= q_c;
      n01_2    <= n01_c;
      d01_2    <= d01_c;
      p2       <= p1;
      m2       <= m1;
      sq2      <= unsigned'(dd1);
      mm2      <= unsigned'(gg1);
      pp_cube2 <= limb_mul(MW'(unsigned'(dd1)), p1);
      far2     <= far1;
      dneg2    <= dneg1;
    end
  end

  // Stage 3: p^3 and the m*q products.
  logic [ABS_W-1:0]      cube3;
  pp_t                   pp_mq3;
  logic signed [Q_W-1:0] n01_3, d01_3;
  logic [IN_W-1:0]       p3, m3;
  logic [SQ_W-1:0]       sq3, mm3;
  logic                  far3, dneg3;

  always_ff @(posedge clk) begin
    if (fen[3]) begin
      cube3  <= limb_sum(pp_cube2);
      pp_mq3 <= limb_mul(MW'(q2), m2);
      n01_3  <= n01_2;
      d01_3  <= d01_2;
      p3     <= p2;
      m3     <= m2;
      sq3    <= sq2;
      mm3    <= mm2;
      far3   <= far2;
      dneg3  <= dneg2;
    end
  end

  // Stage 4: m*q and the p^4 products.
  logic [ABS_W-1:0]      mq4, cube4;
  pp_t                   pp_quart4;
  logic signed [Q_W-1:0] n01_4, d01_4;
  logic [IN_W-1:0]       p4, m4;
  logic [SQ_W-1:0]       sq4, mm4;
  logic                  far4, dneg4;

  always_ff @(posedge clk) begin
    if (fen[4]) begin
      mq4       <= limb_sum(pp_mq3);
      pp_quart4 <= limb_mul(MW'(cube3), p3);
      cube4     <= cube3;
      n01_4     <= n01_3;
      d01_4     <= d01_3;
      p4        <= p3;
      m4        <= m3;
      sq4       <= sq3;
      mm4       <= mm3;
      far4      <= far3;
      dneg4     <= dneg3;
    end
  end

  // Stage 5: p^4 and the m^2*q products.
  logic [ABS_W-1:0]      quart5, mq5, cube5;
  pp_t                   pp_mmq5;
  logic signed [Q_W-1:0] n01_5, d01_5;
  logic [IN_W-1:0]       p5, m5;
  logic [SQ_W-1:0]       sq5, mm5;
  logic                  far5, dneg5;

  always_ff @(posedge clk) begin
    if (fen[5]) begin
      quart5  <= limb_sum(pp_quart4);
      pp_mmq5 <= limb_mul(MW'(mq4), m4);
      mq5     <= mq4;
      cube5   <= cube4;
      n01_5   <= n01_4;
      d01_5   <= d01_4;
      p5      <= p4;
      m5      <= m4;
      sq5     <= sq4;
      mm5     <= mm4;
      far5    <= far4;
      dneg5   <= dneg4;
    end
  end

  // Stage 6: m^2*q.
  logic [ABS_W-1:0]      mmq6, quart6, mq6, cube6;
  logic signed [Q_W-1:0] n01_6, d01_6;
  logic [IN_W-1:0]       p6, m6;
  logic [SQ_W-1:0]       sq6, mm6;
  logic                  far6, dneg6;

  always_ff @(posedge clk) begin
    if (fen[6]) begin
      mmq6   <= limb_sum(pp_mmq5);
      quart6 <= quart5;
      mq6    <= mq5;
      cube6  <= cube5;
      n01_6  <= n01_5;
      d01_6  <= d01_5;
      p6     <= p5;
      m6     <= m5;
      sq6    <= sq5;
      mm6    <= mm5;
      far6   <= far5;
      dneg6  <= dneg5;
    end
  end

  // Stage 7: pick s and the power of |d| for the mode, form U+s and d^k+s.
  logic [ABS_W-1:0]      s_sel, u_sel, ud_sel;
  logic [ABS_W-1:0]      t1_7, t2_7, u7;
  logic signed [Q_W-1:0] n01_7, d01_7;
  logic [IN_W-1:0]       p7, m7;
  logic                  far7;

  always_comb begin
    case (limiter_mode)
      MODE_NISH_R4: begin
        s_sel = mq6 << 1;
        u_sel = cube6;
      end
      MODE_NISH_R5: begin
        s_sel = mmq6 << 3;
        u_sel = quart6;
      end
      default: begin
        s_sel = ABS_W'(mm6) << 2;
        u_sel = ABS_W'(sq6);
      end
    endcase
    // The odd power keeps the sign of delta.
    ud_sel = ((limiter_mode == MODE_NISH_R4) && dneg6) ? -u_sel : u_sel;
  end

  always_ff @(posedge clk) begin
    if (fen[7]) begin
      t1_7  <= u_sel + s_sel;
      t2_7  <= ud_sel + s_sel;
      u7    <= u_sel;
      n01_7 <= n01_6;
      d01_7 <= d01_6;
      p7    <= p6;
      m7    <= m6;
      far7  <= far6;
    end
  end

  // Stage 8: products p*(U+s), m*|d^k+s| and p*U.
  logic [ABS_W-1:0]      t2_abs;
  pp_t                   pp_nn8, pp_mt8, pp_pu8;
  logic                  t2neg8, far8;
  logic signed [Q_W-1:0] n01_8, d01_8;

  assign t2_abs = t2_7[ABS_W-1] ? -t2_7 : t2_7;

  always_ff @(posedge clk) begin
    if (fen[8]) begin
      pp_nn8 <= limb_mul(MW'(t1_7), p7);
      pp_mt8 <= limb_mul(MW'(t2_abs), m7);
      pp_pu8 <= limb_mul(MW'(u7), p7);
      t2neg8 <= t2_7[ABS_W-1];
      n01_8  <= n01_7;
      d01_8  <= d01_7;
      far8   <= far7;
    end
  end

  // Stage 9: sums of the three products.
  logic [ABS_W-1:0]      nn9, mt9, pu9;
  logic                  t2neg9, far9;
  logic signed [Q_W-1:0] n01_9, d01_9;

  always_ff @(posedge clk) begin
    if (fen[9]) begin
      nn9    <= limb_sum(pp_nn8);
      mt9    <= limb_sum(pp_mt8);
      pu9    <= limb_sum(pp_pu8);
      t2neg9 <= t2neg8;
      n01_9  <= n01_8;
      d01_9  <= d01_8;
      far9   <= far8;
    end
  end

  // Stage 10: numerator and denominator with epsilon. On the Nishikawa
  // far side the quotient 1/1 gives exactly one after scaling.
  logic [ABS_W-1:0] eps_x, num_c, den_c;
  logic [ABS_W-1:0] num10, den10;

  assign eps_x = ABS_W'(epsilon);

  always_comb begin
    case (limiter_mode)
      MODE_VENKAT: begin
        num_c = ABS_W'(n01_9) + eps_x;
        den_c = ABS_W'(d01_9) + eps_x;
      end
      MODE_NISH_R3, MODE_NISH_R4, MODE_NISH_R5: begin
        num_c = nn9 + eps_x;
        den_c = pu9 + (t2neg9 ? -mt9 : mt9) + eps_x;
      end
      default: begin
        num_c = ABS_W'(n01_9);
        den_c = ABS_W'(d01_9) + eps_x;
      end
    endcase
    if (far9) begin
      num_c = ABS_W'(1);
      den_c = ABS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fen[10]) begin
      num10 <= num_c;
      den10 <= den_c;
    end
  end

  // Divider, saturation and output register.
  div_req_t div_req;

  assign div_req.num = num10;
  assign div_req.den = den10;

  slu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (fv[NF-1]),
    .req_stall    (div_stall),
    .req          (div_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A stalled entry stage keeps its request.
  a_entry_hold: assert property (@(posedge clk) disable iff (rst)
    (fv[0] && !fen[0]) |=> (fv[0] && $stable(g0) && $stable(d0)))
    else $error("entry stage lost or changed a stalled request");

  // A request held back by the divider stays intact.
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (fv[NF-1] && div_stall) |=> (fv[NF-1] && $stable(num10) && $stable(den10)))
    else $error("request to the divider changed while stalled");

  // The stored mode is always a defined formula.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    limiter_mode <= MODE_NISH_R5)
    else $error("limiter mode holds an undefined code");

endmodule

FILE: tb/slope_limiter_unit_core_tb.sv
// ----------------------------------------------------------------------------
// Slope limiter unit testbench
// Streams gradient and delta pairs through the limiter under every mode and a
// range of smoothing terms. A scoreboard predicts each limiter factor with
// exact wide integer arithmetic and checks results in order. The sender
// idles and the receiver stalls at random; one long hold-off, many drains.
// ----------------------------------------------------------------------------
module slope_limiter_unit_core_tb;
  import slu_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd2;
  localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};

  // Limiter factor predictor and store of factors still awaited.
  class limiter_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [EPS_W-1:0]  eps;
    result_t           awaited[$];
    int                errors;

    function new();
      mode = MODE_VAN_ALBADA;
      eps = EPS_W'(1);
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [EPS_W-1:0] data);
      if (idx == REG_LIMITER_MODE) mode = data[MODE_W-1:0];
      else if (idx == REG_EPSILON) eps = data;
    endfunction

    function result_t limiter_factor(item_t it);
      logic signed [255:0] g, d, e, p, m, p2, d2, y, s, num, den;
      logic [255:0] un, ud, q, lim;
      logic neg;
      logic [MODE_W-1:0] md;
      result_t r;
      g = $signed(it.gradient);
      d = $signed(it.delta);
      e = $signed({193'd0, eps});
      p = (d < 0) ? -d : d;
      m = (g < 0) ? -g : g;
      md = (mode > MODE_NISH_R5) ? MODE_VAN_ALBADA : mode;
      // Nishikawa limiters return exactly one on the far side.
      if (md >= MODE_NISH_R3 && p > 2 * m) begin
        r.limit_value = 21'(1 << FRAC);
        r.saturated = 1'b0;
        return r;
      end
      p2 = p * p;
      d2 = d * d;
      case (md)
        MODE_VAN_ALBADA: begin
          num = d * (2 * g + d);
          den = 4 * g * g + d2 + e;
        end
        MODE_VENKAT: begin
          y = d * (d + g) + e;
          num = y + d * g;
          den = y + 2 * g * g;
        end
        MODE_NISH_R3: begin
          y = p2 * p + e;
          s = 4 * m * m;
          num = y + p * s;
          den = y + m * (d2 + s);
        end
        MODE_NISH_R4: begin
          y = p2 * p2 + e;
          s = 2 * m * (p2 - 2 * m * (p - 2 * m));
          num = y + p * s;
          den = y + m * (d2 * d + s);
        end
        default: begin
          y = p2 * p2 * p + e;
          s = 8 * m * m * (p2 - 2 * m * (p - m));
          num = y + p * s;
          den = y + m * (d2 * d2 + s);
        end
      endcase
      if (den == 0) begin
        r.limit_value = '0;
        r.saturated = 1'b1;
        return r;
      end
      // Divide magnitudes, truncate toward zero, then clip to Q4.16.
      neg = num[255] ^ den[255];
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (un << FRAC) / ud;
      lim = neg ? 256'd1048576 : 256'd1048575;
      r.saturated = 1'b0;
      if (q > lim) begin
        q = lim;
        r.saturated = 1'b1;
      end
      r.limit_value = neg ? -q[LIMIT_W-1:0] : q[LIMIT_W-1:0];
      return r;
    endfunction

    function void note_request(item_t it);
      awaited.push_back(limiter_factor(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: limit_value %0d saturated %0b",
               got.limit_value, got.saturated);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.limit_value !== want.limit_value) begin
        $error("limit_value: expected %0d, actual %0d", want.limit_value, got.limit_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [EPS_W-1:0] cfg_data = '0;

  limiter_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  slope_limiter_unit_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, a quiet stretch, and one long hold-off on demand.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // Result checking.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("slope_limiter_unit_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(item_t it);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_request(it);
    if (!quiet && $urandom_range(99) < 7) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic pause_sender();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    pause_sender();
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [EPS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t pair(int gv, int dv);
    item_t it;
    it.gradient = gv[IN_W-1:0];
    it.delta = dv[IN_W-1:0];
    return it;
  endfunction

  // Random pair: full range, small values, or delta near a multiple of half the gradient.
  function automatic item_t random_pair();
    item_t it;
    int gv, dv, kind;
    kind = $urandom_range(3);
    if (kind == 0) begin
      it.gradient = IN_W'($urandom);
      it.delta = IN_W'($urandom);
      return it;
    end
    if (kind == 1) begin
      gv = int'($urandom_range(2048)) - 1024;
      dv = int'($urandom_range(2048)) - 1024;
    end else begin
      gv = $urandom_range(8388607) >> $urandom_range(20);
      if ($urandom_range(1)) gv = -gv;
      dv = (gv * (int'($urandom_range(8)) - 4)) / 2 + (int'($urandom_range(64)) - 32);
      if (dv > 8388607) dv = 8388607;
      if (dv < -8388608) dv = -8388608;
    end
    return pair(gv, dv);
  endfunction

  initial begin
    int dg[] = '{0, 8388607, -8388608, -8388608, 8388607, 0, 8388607, 1, 1, 1, -1,
                 65536, -65536, 0, 3};
    int dd[] = '{0, 8388607, -8388608, 8388607, -8388608, 8388607, 0, -1, 3, 2, 2,
                 65536, 131072, -5, -7};
    logic [MODE_W-1:0] modes[] = '{MODE_VAN_ALBADA, MODE_VENKAT, MODE_NISH_R3,
                                   MODE_NISH_R4, MODE_NISH_R5, 3'd5, 3'd7,
                                   MODE_NISH_R3, MODE_VENKAT, MODE_NISH_R5};
    logic [EPS_W-1:0] eps_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed extremes under reset settings, then zero smoothing term.
    for (int i = 0; i < dg.size(); i++) send_request(pair(dg[i], dd[i]));
    drain();
    write_reg(REG_EPSILON, '0);
    for (int i = 0; i < 6; i++) send_request(pair(dg[i], dd[i]));
    drain();

    for (int ph = 0; ph < modes.size(); ph++) begin
      case (ph % 5)
        0: eps_val = '0;
        1: eps_val = EPS_W'(1);
        2: eps_val = EPS_MAX;
        3: eps_val = EPS_W'($urandom_range(1 << 20));
        default: eps_val = EPS_W'({$urandom, $urandom});
      endcase
      write_reg(REG_LIMITER_MODE, EPS_W'(modes[ph]));
      write_reg(REG_EPSILON, eps_val);
      // A write to an unused index must leave both registers alone.
      if (ph == 4) write_reg(REG_UNUSED, EPS_W'({$urandom, $urandom}));
      quiet = (ph == 6);
      for (int n = 0; n < 165; n++) begin
        if (ph == 2 && n == 20) hold_req++;
        if (ph == 3 && n == 80) drain();
        if (n < 8) send_request(pair(dg[n], dd[n]));
        else send_request(random_pair());
      end
      quiet = 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("slope_limiter_unit_core: match");
    end else begin
      $display("slope_limiter_unit_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: slope_limiter_unit_core.f
src/slu_pkg.sv
src/slu_div.sv
src/slope_limiter_unit_core.sv
tb/slope_limiter_unit_core_tb.sv
